/* hdl/tkdr_pkg.sv */
// ----------------------------------------------------------------------------
// tkdr_pkg
// Shared types and constants for the tilt key debounce and autorepeat block.
// ----------------------------------------------------------------------------
package tkdr_pkg;

	localparam int MASK_W   = 4;
	localparam int AXIS_W   = 16;
	localparam int MS_W     = 16;
	localparam int CNT_W    = 3;
	localparam int CFG_W    = 64;
	localparam int IDX_W    = 3;
	localparam int NUM_WIN  = 6;

	localparam int NUM_KEYS_DEF       = 4;
	localparam int DEBOUNCE_COUNT_DEF = 5;

	localparam logic [MS_W-1:0] BLOCK_TIME_RST      = 16'd900;
	localparam logic [MS_W-1:0] REPEAT_INTERVAL_RST = 16'd500;

	// register indexes of the configuration port
	typedef enum logic [IDX_W-1:0] {
		REG_X_LOW      = 3'd0,
		REG_X_HIGH     = 3'd1,
		REG_Y_LOW      = 3'd2,
		REG_Y_HIGH     = 3'd3,
		REG_Z_LOW      = 3'd4,
		REG_Z_HIGH     = 3'd5,
		REG_BLOCK_TIME = 3'd6,
		REG_REPEAT     = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_RELEASED = 2'd0,
		MODE_PRESSED  = 2'd1,
		MODE_LONG     = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
		logic        [MS_W-1:0]   dt;
	} word_t;

	typedef struct packed {
		logic [MASK_W-1:0] fire;
		logic [MASK_W-1:0] held;
		logic [MASK_W-1:0] lng;
	} masks_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x_lo;
		logic signed [AXIS_W-1:0] x_hi;
		logic signed [AXIS_W-1:0] y_lo;
		logic signed [AXIS_W-1:0] y_hi;
		logic signed [AXIS_W-1:0] z_lo;
		logic signed [AXIS_W-1:0] z_hi;
	} window_t;

endpackage

/* hdl/tkdr_cell.sv */
// ----------------------------------------------------------------------------
// tkdr_cell
// One tilt key: window test, debounce, block time and repeat, plus one
// pipeline stage that hands the sample word and partial masks onwards.
// ----------------------------------------------------------------------------
module tkdr_cell #(
	parameter int KEY_IDX        = 0,
	parameter int DEBOUNCE_COUNT = tkdr_pkg::DEBOUNCE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  tkdr_pkg::window_t             win,
	input  logic [tkdr_pkg::MS_W-1:0]     block_time,
	input  logic [tkdr_pkg::MS_W-1:0]     repeat_interval,
	input  logic                          valid_in,
	input  tkdr_pkg::word_t               word_in,
	input  tkdr_pkg::masks_t              masks_in,
	output logic                          valid_out,
	output tkdr_pkg::word_t               word_out,
	output tkdr_pkg::masks_t              masks_out
);

	localparam logic [tkdr_pkg::MASK_W-1:0] KEY_BIT =
		tkdr_pkg::MASK_W'(1) << KEY_IDX;
	localparam logic [tkdr_pkg::CNT_W:0] CNT_TOP = (tkdr_pkg::CNT_W+1)'(DEBOUNCE_COUNT);

	tkdr_pkg::mode_t                 mode_q, mode_d;
	logic [tkdr_pkg::CNT_W-1:0]      count_q, count_d;
	logic [tkdr_pkg::MS_W-1:0]       block_q, block_d;
	logic [tkdr_pkg::MS_W-1:0]       acc_q, acc_d;
	logic                            hit, fire;
	logic [tkdr_pkg::MS_W:0]         acc_sum;
	logic [tkdr_pkg::MS_W-1:0]       acc_sat;
	logic [tkdr_pkg::CNT_W:0]        cnt_inc;

	logic                            valid_s1;
	tkdr_pkg::word_t                 word_s1;
	tkdr_pkg::masks_t                masks_s1;

	// strict signed window on all three axes
	assign hit = (win.x_lo < word_in.x) && (word_in.x < win.x_hi) &&
	             (win.y_lo < word_in.y) && (word_in.y < win.y_hi) &&
	             (win.z_lo < word_in.z) && (word_in.z < win.z_hi);

	assign acc_sum = {1'b0, acc_q} + {1'b0, word_in.dt};
	assign acc_sat = acc_sum[tkdr_pkg::MS_W] ? '1 : acc_sum[tkdr_pkg::MS_W-1:0];
	assign cnt_inc = {1'b0, count_q} + (tkdr_pkg::CNT_W+1)'(1);

	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		block_d = block_q;
		acc_d   = acc_q;
		fire    = 1'b0;
		unique case (mode_q)
			tkdr_pkg::MODE_PRESSED: begin
				if (!hit) begin
					mode_d = tkdr_pkg::MODE_RELEASED;
				end else if (block_q != '0) begin
					block_d = (word_in.dt < block_q) ? block_q - word_in.dt : '0;
				end else begin
					mode_d = tkdr_pkg::MODE_LONG;
				end
			end
			tkdr_pkg::MODE_LONG: begin
				if (hit) begin
					if (acc_sat >= repeat_interval) begin
						acc_d = '0;
						fire  = 1'b1;
					end else begin
						acc_d = acc_sat;
					end
				end else begin
					acc_d  = '0;
					mode_d = tkdr_pkg::MODE_RELEASED;
				end
			end
			default: begin
				mode_d = tkdr_pkg::MODE_RELEASED;
				if (hit) begin
					if (cnt_inc >= CNT_TOP) begin
						count_d = '0;
						block_d = block_time;
						acc_d   = '0;
						mode_d  = tkdr_pkg::MODE_PRESSED;
						fire    = 1'b1;
					end else begin
						count_d = cnt_inc[tkdr_pkg::CNT_W-1:0];
					end
				end else if (count_q != '0) begin
					count_d = count_q - tkdr_pkg::CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tkdr_pkg::MODE_RELEASED;
			count_q  <= '0;
			block_q  <= '0;
			acc_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
			if (valid_in) begin
				mode_q  <= mode_d;
				count_q <= count_d;
				block_q <= block_d;
				acc_q   <= acc_d;
			end
		end
	end

	// word and masks move on with the stage, own bit merged in
	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1       <= word_in;
			masks_s1.fire <= masks_in.fire | (fire ? KEY_BIT : '0);
			masks_s1.held <= masks_in.held |
				((mode_d == tkdr_pkg::MODE_PRESSED || mode_d == tkdr_pkg::MODE_LONG) ?
				 KEY_BIT : '0);
			masks_s1.lng  <= masks_in.lng |
				((mode_d == tkdr_pkg::MODE_LONG) ? KEY_BIT : '0);
		end
	end

	assign valid_out = valid_s1;
	assign word_out  = word_s1;
	assign masks_out = masks_s1;

endmodule

/* hdl/tilt_key_debounce_repeat.sv */
// ----------------------------------------------------------------------------
// tilt_key_debounce_repeat
// Virtual tilt keys from accelerometer samples, with debounce and autorepeat.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   accel_x, accel_y, accel_z, elapsed_ms
//  out      out_valid / out_ready fire_mask, held_mask, long_mask
//  cfg      cfg_we                cfg_index, cfg_data
//
// one word accepted per cycle unless the row holds; each key is a cell in a row,
// and the word walks one cell per cycle, with the result leaving the last cell
// the whole row holds when the output word waits and out_ready is low
// reset clears key states and loads register defaults (windows 0, 900, 500)
// ----------------------------------------------------------------------------
module tilt_key_debounce_repeat #(
	parameter int NUM_KEYS       = tkdr_pkg::NUM_KEYS_DEF,
	parameter int DEBOUNCE_COUNT = tkdr_pkg::DEBOUNCE_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tkdr_pkg::AXIS_W-1:0]   accel_x,
	input  logic signed [tkdr_pkg::AXIS_W-1:0]   accel_y,
	input  logic signed [tkdr_pkg::AXIS_W-1:0]   accel_z,
	input  logic        [tkdr_pkg::MS_W-1:0]     elapsed_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [tkdr_pkg::MASK_W-1:0]   fire_mask,
	output logic        [tkdr_pkg::MASK_W-1:0]   held_mask,
	output logic        [tkdr_pkg::MASK_W-1:0]   long_mask,
	input  logic                                 cfg_we,
	input  logic        [tkdr_pkg::IDX_W-1:0]    cfg_index,
	input  logic        [tkdr_pkg::CFG_W-1:0]    cfg_data
);

	logic [tkdr_pkg::CFG_W-1:0] win_q [tkdr_pkg::NUM_WIN];
	logic [tkdr_pkg::MS_W-1:0]  block_time_q;
	logic [tkdr_pkg::MS_W-1:0]  repeat_q;

	logic                       advance;
	logic [NUM_KEYS:0]          valid_c;
	tkdr_pkg::word_t            word_c  [NUM_KEYS+1];
	tkdr_pkg::masks_t           masks_c [NUM_KEYS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < tkdr_pkg::NUM_WIN; r++) begin
				win_q[r] <= '0;
			end
			block_time_q <= tkdr_pkg::BLOCK_TIME_RST;
			repeat_q     <= tkdr_pkg::REPEAT_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (tkdr_pkg::reg_idx_t'(cfg_index))
				tkdr_pkg::REG_BLOCK_TIME: block_time_q <= cfg_data[tkdr_pkg::MS_W-1:0];
				tkdr_pkg::REG_REPEAT:     repeat_q     <= cfg_data[tkdr_pkg::MS_W-1:0];
				default: begin
					win_q[cfg_index] <= cfg_data;
				end
			endcase
		end
	end

	// the row moves whenever the last stage is empty or being drained
	assign advance  = !valid_c[NUM_KEYS] || out_ready;
	assign in_ready = advance;

	assign valid_c[0]      = in_valid;
	assign word_c[0].x     = accel_x;
	assign word_c[0].y     = accel_y;
	assign word_c[0].z     = accel_z;
	assign word_c[0].dt    = elapsed_ms;
	assign masks_c[0]      = '0;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		tkdr_pkg::window_t win;

		assign win.x_lo = win_q[tkdr_pkg::REG_X_LOW ][16*k +: 16];
		assign win.x_hi = win_q[tkdr_pkg::REG_X_HIGH][16*k +: 16];
		assign win.y_lo = win_q[tkdr_pkg::REG_Y_LOW ][16*k +: 16];
		assign win.y_hi = win_q[tkdr_pkg::REG_Y_HIGH][16*k +: 16];
		assign win.z_lo = win_q[tkdr_pkg::REG_Z_LOW ][16*k +: 16];
		assign win.z_hi = win_q[tkdr_pkg::REG_Z_HIGH][16*k +: 16];

		tkdr_cell #(
			.KEY_IDX        (k),
			.DEBOUNCE_COUNT (DEBOUNCE_COUNT)
		) u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.advance         (advance),
			.win             (win),
			.block_time      (block_time_q),
			.repeat_interval (repeat_q),
			.valid_in        (valid_c[k]),
			.word_in         (word_c[k]),
			.masks_in        (masks_c[k]),
			.valid_out       (valid_c[k+1]),
			.word_out        (word_c[k+1]),
			.masks_out       (masks_c[k+1])
		);
	end

	assign out_valid = valid_c[NUM_KEYS];
	assign fire_mask = masks_c[NUM_KEYS].fire;
	assign held_mask = masks_c[NUM_KEYS].held;
	assign long_mask = masks_c[NUM_KEYS].lng;

endmodule

/* tb/tkdr_key_checker.sv */
// ----------------------------------------------------------------------------
// tkdr_key_checker
// Watches the sample and mask channels and the register port of the tilt key
// block, keeps its own copy of the key states, and compares every mask word
// with the one it predicts for the oldest sample still in flight.
// ----------------------------------------------------------------------------
module tkdr_key_checker import tkdr_pkg::*; #(
	parameter int NUM_KEYS       = NUM_KEYS_DEF,
	parameter int DEBOUNCE_COUNT = DEBOUNCE_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [AXIS_W-1:0] accel_x,
	input  logic signed [AXIS_W-1:0] accel_y,
	input  logic signed [AXIS_W-1:0] accel_z,
	input  logic        [MS_W-1:0]   elapsed_ms,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic        [MASK_W-1:0] fire_mask,
	input  logic        [MASK_W-1:0] held_mask,
	input  logic        [MASK_W-1:0] long_mask,
	input  logic                     cfg_we,
	input  logic        [IDX_W-1:0]  cfg_index,
	input  logic        [CFG_W-1:0]  cfg_data,
	output int                       fail_count,
	output int                       words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_W-1:0] win_q [NUM_WIN];
	logic [MS_W-1:0]  block_cfg;
	logic [MS_W-1:0]  repeat_cfg;

	mode_t            mode_q       [NUM_KEYS];
	logic [CNT_W-1:0] cnt_q        [NUM_KEYS];
	logic [MS_W-1:0]  block_left_q [NUM_KEYS];
	logic [MS_W-1:0]  acc_q        [NUM_KEYS];

	masks_t masks_due [$];
	masks_t got_masks;
	masks_t want_masks;

	function automatic bit axis_in(logic [CFG_W-1:0] lo_bank, logic [CFG_W-1:0] hi_bank,
			int k, logic signed [AXIS_W-1:0] v);
		logic signed [AXIS_W-1:0] lo;
		logic signed [AXIS_W-1:0] hi;
		lo = lo_bank[AXIS_W*k +: AXIS_W];
		hi = hi_bank[AXIS_W*k +: AXIS_W];
		return (lo < v) && (v < hi);
	endfunction

	function automatic bit key_hit(int k, word_t w);
		return axis_in(win_q[REG_X_LOW], win_q[REG_X_HIGH], k, w.x)
			&& axis_in(win_q[REG_Y_LOW], win_q[REG_Y_HIGH], k, w.y)
			&& axis_in(win_q[REG_Z_LOW], win_q[REG_Z_HIGH], k, w.z);
	endfunction

	// one sample through every key, state updated in place
	function automatic masks_t advance_keys(word_t w);
		masks_t         m;
		bit             hit;
		logic [MS_W:0]  acc;
		logic [CNT_W:0] cnt_n;
		m = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			hit = key_hit(k, w);
			case (mode_q[k])
				MODE_PRESSED: begin
					if (!hit)
						mode_q[k] = MODE_RELEASED;
					else if (block_left_q[k] != '0)
						block_left_q[k] = (w.dt < block_left_q[k]) ?
							block_left_q[k] - w.dt : '0;
					else
						mode_q[k] = MODE_LONG;
				end
				MODE_LONG: begin
					if (hit) begin
						acc = acc_q[k] + w.dt;
						if (acc > {1'b0, {MS_W{1'b1}}})
							acc = {1'b0, {MS_W{1'b1}}};
						if (acc >= repeat_cfg) begin
							acc = '0;
							m.fire[k] = 1'b1;
						end
						acc_q[k] = acc[MS_W-1:0];
					end else begin
						acc_q[k] = '0;
						mode_q[k] = MODE_RELEASED;
					end
				end
				// the unused code falls in here with released
				default: begin
					mode_q[k] = MODE_RELEASED;
					if (hit) begin
						cnt_n = cnt_q[k] + 1'b1;
						if (cnt_n >= DEBOUNCE_COUNT) begin
							cnt_q[k] = '0;
							block_left_q[k] = block_cfg;
							acc_q[k] = '0;
							mode_q[k] = MODE_PRESSED;
							m.fire[k] = 1'b1;
						end else begin
							cnt_q[k] = cnt_n[CNT_W-1:0];
						end
					end else if (cnt_q[k] != '0) begin
						cnt_q[k] = cnt_q[k] - 1'b1;
					end
				end
			endcase
			m.held[k] = (mode_q[k] == MODE_PRESSED) || (mode_q[k] == MODE_LONG);
			m.lng[k]  = (mode_q[k] == MODE_LONG);
		end
		return m;
	endfunction

	function automatic void check_field(string name, logic [MASK_W-1:0] want_v,
			logic [MASK_W-1:0] got_v);
		if (want_v !== got_v) begin
			fail_count++;
			$display("%0t ns: %s expected %b got %b", $time, name, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN; i++)
				win_q[i] = '0;
			block_cfg  = BLOCK_TIME_RST;
			repeat_cfg = REPEAT_INTERVAL_RST;
			for (int k = 0; k < NUM_KEYS; k++) begin
				mode_q[k]       = MODE_RELEASED;
				cnt_q[k]        = '0;
				block_left_q[k] = '0;
				acc_q[k]        = '0;
			end
			masks_due.delete();
			words_due  = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BLOCK_TIME: block_cfg  = cfg_data[MS_W-1:0];
					REG_REPEAT:     repeat_cfg = cfg_data[MS_W-1:0];
					REG_X_LOW, REG_X_HIGH, REG_Y_LOW, REG_Y_HIGH, REG_Z_LOW, REG_Z_HIGH:
						win_q[cfg_index] = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got_masks = {fire_mask, held_mask, long_mask};
				if (masks_due.size() == 0) begin
					fail_count++;
					$display("%0t ns: mask word with none expected, got fire %b held %b long %b",
						$time, fire_mask, held_mask, long_mask);
				end else begin
					want_masks = masks_due.pop_front();
					check_field("fire_mask", want_masks.fire, got_masks.fire);
					check_field("held_mask", want_masks.held, got_masks.held);
					check_field("long_mask", want_masks.lng, got_masks.lng);
				end
			end
			if (in_valid && in_ready)
				masks_due.push_back(advance_keys({accel_x, accel_y, accel_z, elapsed_ms}));
			words_due = masks_due.size();
		end
	end

endmodule

/* tb/tilt_key_debounce_repeat_tb.sv */
// ----------------------------------------------------------------------------
// tilt_key_debounce_repeat_tb
// Drives accelerometer samples into the tilt key block under several window,
// block time and repeat settings: a short directed run over the edge cases,
// then tilt runs aimed at one key at a time mixed with noise. Both sides
// stall at random; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tilt_key_debounce_repeat_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tkdr_pkg::*;

	localparam int NKEYS       = NUM_KEYS_DEF;
	localparam int DEB         = DEBOUNCE_COUNT_DEF;
	localparam int LANES       = CFG_W / AXIS_W;
	localparam int NUM_REGS    = 2 ** IDX_W;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 250;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 4 * NKEYS + 4;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {AX_X, AX_Y, AX_Z} axis_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic signed [AXIS_W-1:0] accel_x    = '0;
	logic signed [AXIS_W-1:0] accel_y    = '0;
	logic signed [AXIS_W-1:0] accel_z    = '0;
	logic        [MS_W-1:0]   elapsed_ms = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic        [MASK_W-1:0] fire_mask;
	logic        [MASK_W-1:0] held_mask;
	logic        [MASK_W-1:0] long_mask;
	logic                     cfg_we     = 1'b0;
	logic        [IDX_W-1:0]  cfg_index  = '0;
	logic        [CFG_W-1:0]  cfg_data   = '0;
	int                       fail_count;
	int                       words_due;

	logic signed [AXIS_W-1:0] win_lo [3][LANES];
	logic signed [AXIS_W-1:0] win_hi [3][LANES];
	logic        [MS_W-1:0]   block_ms;
	logic        [MS_W-1:0]   repeat_ms;

	bit quiet    = 1'b0;
	bit hold_req = 1'b0;
	int cycles   = 0;

	tilt_key_debounce_repeat #(.NUM_KEYS(NKEYS), .DEBOUNCE_COUNT(DEB)) u_top (.*);

	tkdr_key_checker #(.NUM_KEYS(NKEYS), .DEBOUNCE_COUNT(DEB)) u_check (.*);

	always #6 clk = ~clk;

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		bit rdy;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				rdy       = 1'b0;
			end else begin
				rdy = quiet || ($urandom_range(99) >= 16);
			end
			out_ready <= rdy;
		end
	end

	task automatic offer(input logic signed [AXIS_W-1:0] x, input logic signed [AXIS_W-1:0] y,
			input logic signed [AXIS_W-1:0] z, input logic [MS_W-1:0] dt);
		while (!quiet && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		accel_x    <= x;
		accel_y    <= y;
		accel_z    <= z;
		elapsed_ms <= dt;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_masks_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_config();
		logic [CFG_W-1:0] bank [NUM_REGS];
		for (int k = 0; k < LANES; k++) begin
			bank[REG_X_LOW][AXIS_W*k +: AXIS_W]  = win_lo[AX_X][k];
			bank[REG_X_HIGH][AXIS_W*k +: AXIS_W] = win_hi[AX_X][k];
			bank[REG_Y_LOW][AXIS_W*k +: AXIS_W]  = win_lo[AX_Y][k];
			bank[REG_Y_HIGH][AXIS_W*k +: AXIS_W] = win_hi[AX_Y][k];
			bank[REG_Z_LOW][AXIS_W*k +: AXIS_W]  = win_lo[AX_Z][k];
			bank[REG_Z_HIGH][AXIS_W*k +: AXIS_W] = win_hi[AX_Z][k];
		end
		// junk above the 16 bits that the timing registers keep
		bank[REG_BLOCK_TIME] = {$urandom(), $urandom()};
		bank[REG_BLOCK_TIME][MS_W-1:0] = block_ms;
		bank[REG_REPEAT] = {$urandom(), $urandom()};
		bank[REG_REPEAT][MS_W-1:0] = repeat_ms;
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data  <= bank[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic int clamp16(int v);
		if (v < -32768)
			return -32768;
		if (v > 32767)
			return 32767;
		return v;
	endfunction

	task automatic roll_windows();
		int r;
		int c;
		int hw;
		int v;
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < LANES; k++) begin
				r = $urandom_range(99);
				if (r < 70) begin
					// keys often share a centre so several fire together
					if ($urandom_range(99) < 40)
						c = int'($urandom_range(2000)) - 1000;
					else
						c = int'($urandom_range(65535)) - 32768;
					hw = $urandom_range(12000, 50);
					win_lo[a][k] = AXIS_W'(clamp16(c - hw));
					win_hi[a][k] = AXIS_W'(clamp16(c + hw));
				end else if (r < 80) begin
					win_lo[a][k] = 16'sh8000;
					win_hi[a][k] = 16'sh7FFF;
				end else if (r < 88) begin
					// no value strictly between the bounds
					v = int'($urandom_range(65533)) - 32767;
					win_lo[a][k] = AXIS_W'(v);
					win_hi[a][k] = AXIS_W'(v + int'($urandom_range(2)) - 1);
				end else begin
					win_lo[a][k] = AXIS_W'($urandom);
					win_hi[a][k] = AXIS_W'($urandom);
				end
			end
		end
	endtask

	function automatic logic signed [AXIS_W-1:0] pick_between(logic signed [AXIS_W-1:0] lo,
			logic signed [AXIS_W-1:0] hi);
		int span;
		span = int'(hi) - int'(lo);
		if (span < 2)
			return AXIS_W'($urandom);
		return AXIS_W'(int'(lo) + 1 + int'($urandom_range(span - 2)));
	endfunction

	function automatic logic signed [AXIS_W-1:0] noise_axis();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return 16'sh8000;
		if (r < 12)
			return 16'sh7FFF;
		if (r < 16)
			return '0;
		return AXIS_W'($urandom);
	endfunction

	function automatic logic [MS_W-1:0] pick_elapsed();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return MS_W'($urandom_range(150));
		if (r < 75)
			return '0;
		if (r < 85)
			return MS_W'($urandom_range(2000));
		if (r < 92)
			return '1;
		return MS_W'($urandom);
	endfunction

	// tilt runs held on one key, a few misses inside, noise between runs
	task automatic run_phase(int words);
		int tgt;
		int run_left;
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
		tgt = -1;
		run_left = 0;
		repeat (words) begin
			if (run_left == 0) begin
				if ($urandom_range(99) < 80) begin
					tgt = $urandom_range(NKEYS - 1);
					run_left = $urandom_range(60, 1);
				end else begin
					tgt = -1;
					run_left = $urandom_range(6, 1);
				end
			end
			run_left--;
			if (tgt >= 0 && $urandom_range(99) < 92) begin
				x = pick_between(win_lo[AX_X][tgt], win_hi[AX_X][tgt]);
				y = pick_between(win_lo[AX_Y][tgt], win_hi[AX_Y][tgt]);
				z = pick_between(win_lo[AX_Z][tgt], win_hi[AX_Z][tgt]);
			end else begin
				x = noise_axis();
				y = noise_axis();
				z = noise_axis();
			end
			offer(x, y, z, pick_elapsed());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset windows are all empty, nothing may press
		offer(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF);
		offer(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000);
		wait_masks_done();

		// key 0 open everywhere, key 1 narrow in x, key 2 equal bounds, key 3 reversed
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < LANES; k++) begin
				win_lo[a][k] = 16'sh8000;
				win_hi[a][k] = 16'sh7FFF;
			end
			win_lo[a][2] = 16'sd5;
			win_hi[a][2] = 16'sd5;
			win_lo[a][3] = 16'sd100;
			win_hi[a][3] = -16'sd100;
		end
		win_lo[AX_X][1] = -16'sd100;
		win_hi[AX_X][1] = 16'sd100;
		block_ms  = 16'd3;
		repeat_ms = 16'd0;
		write_config();
		offer(16'sd200, 16'sd0, 16'sd0, 16'd0);   // key 1 out at count zero
		repeat (5) offer(16'sd0, 16'sd0, 16'sd0, 16'd1);
		offer(16'sd0, 16'sd0, 16'sd0, 16'd2);
		offer(16'sd0, 16'sd0, 16'sd0, 16'hFFFF);   // block countdown stops at zero
		offer(16'sd0, 16'sd0, 16'sd0, 16'd0);      // into long press, no fire
		offer(16'sd0, 16'sd0, 16'sd0, 16'd0);      // zero interval refires
		offer(16'sh7FFF, 16'sd0, 16'sd0, 16'd7);   // bound itself is outside
		wait_masks_done();

		block_ms  = 16'd0;
		repeat_ms = 16'hFFFF;
		write_config();
		repeat (5) offer(16'sd1, -16'sd1, 16'sd1, 16'd0);
		offer(16'sd1, -16'sd1, 16'sd1, 16'd0);
		offer(16'sd1, -16'sd1, 16'sd1, 16'hFFFF);
		offer(16'sd1, -16'sd1, 16'sd1, 16'hFFFF);  // a full interval in one sample fires again
		offer(16'sd1, -16'sd1, 16'sd1, 16'd100);
		offer(16'sh8000, 16'sh8000, 16'sh8000, 16'd0);
		offer(16'sd0, 16'sh7FFF, 16'sh8000, 16'd1);
		wait_masks_done();

		for (int p = 0; p < PHASES; p++) begin
			roll_windows();
			case (p)
				0: begin
					block_ms  = '0;
					repeat_ms = '0;
				end
				1: begin
					block_ms  = '1;
					repeat_ms = '1;
				end
				2: begin
					block_ms  = BLOCK_TIME_RST;
					repeat_ms = REPEAT_INTERVAL_RST;
				end
				default: begin
					if ($urandom_range(99) < 75) begin
						block_ms  = MS_W'($urandom_range(1500));
						repeat_ms = MS_W'($urandom_range(800));
					end else begin
						block_ms  = MS_W'($urandom);
						repeat_ms = MS_W'($urandom);
					end
				end
			endcase
			write_config();
			quiet = (p == 3);
			if (p == 2)
				hold_req = 1'b1;
			run_phase(PHASE_WORDS);
			wait_masks_done();
		end
		quiet = 1'b0;

		if (fail_count == 0 && words_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
hdl/tkdr_pkg.sv
hdl/tkdr_cell.sv
hdl/tilt_key_debounce_repeat.sv
tb/tkdr_key_checker.sv
tb/tilt_key_debounce_repeat_tb.sv
